// File: rtl/lcdnw_pkg.sv
// Shared types and constants for the LCD decimal number writer.
// Used by every module of the block; depends on nothing else.
package lcdnw_pkg;

   // Width of the number and the decimal digits it can need.
   localparam int VALUE_WIDTH = 16;
   // floor(VALUE_WIDTH * log10(2)) + 1, exact over the widths 4 to 32.
   localparam int DIGITS      = ((VALUE_WIDTH * 1233) >> 12) + 1;
   localparam int CNT_W       = $clog2(DIGITS + 1);
   localparam int IDX_W       = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam int COL_W       = 6;

   // Bus encoding of the display controller.
   localparam logic [7:0] SET_ADDR_CMD = 8'd128;
   localparam logic [7:0] ROW_OFFSET   = 8'h40;
   localparam logic [7:0] ASCII_ZERO   = 8'd48;

   // Division by ten: q = (v * RECIP_TEN) >> RECIP_SHIFT, exact for v below 2**32.
   localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;

   // Depth of the queue between the converter and the byte sequencer.
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      logic [COL_W-1:0]       column;
      logic                   row;
   } req_type;

   typedef struct packed {
      logic       is_data;
      logic [7:0] bus_byte;
      logic       last;
   } rsp_type;

   // One converted number: digits least significant first, and their count.
   typedef struct packed {
      logic [DIGITS-1:0][3:0] digits;
      logic [CNT_W-1:0]       count;
      logic [COL_W-1:0]       column;
      logic                   row;
   } job_type;

endpackage

// File: rtl/lcdnw_front.sv
// Front end: accepts numbers and splits them into decimal digits.
// Depends on lcdnw_pkg; hands finished jobs to lcdnw_queue.
module lcdnw_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  lcdnw_pkg::req_type req_data,
   output logic              job_push,
   input  logic              job_full,
   output lcdnw_pkg::job_type job_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_REM  = 2'd2;
   localparam logic [1:0] ST_PUSH = 2'd3;

   logic [1:0]                        state_ff, state_in;
   logic [lcdnw_pkg::VALUE_WIDTH-1:0] value_ff, value_in;
   logic [lcdnw_pkg::VALUE_WIDTH-1:0] quot_ff, quot_in;
   lcdnw_pkg::job_type                job_ff, job_in;
   logic [63:0]                       product;
   logic [63:0]                       quot_wide;
   logic [3:0]                        rem_digit;

   // Quotient by ten through the reciprocal multiply.
   assign product   = 64'({{(32 - lcdnw_pkg::VALUE_WIDTH){1'b0}}, value_ff})
                      * 64'(lcdnw_pkg::RECIP_TEN);
   assign quot_wide = product >> lcdnw_pkg::RECIP_SHIFT;

   // The remainder is below ten, so the low four bits of v - 10q suffice.
   assign rem_digit = value_ff[3:0] - ({quot_ff[0], 3'b000} + {quot_ff[2:0], 1'b0});

   assign full     = (state_ff != ST_IDLE);
   assign job_push = (state_ff == ST_PUSH) && !job_full;
   assign job_data = job_ff;

   // Conversion sequencer: each digit takes a divide step (ST_DIV) and then a remainder step (ST_REM).
   always_comb begin
      state_in = state_ff;
      value_in = value_ff;
      quot_in  = quot_ff;
      job_in   = job_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (push) begin
               value_in      = req_data.value;
               job_in.column = req_data.column;
               job_in.row    = req_data.row;
               job_in.count  = '0;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            quot_in  = quot_wide[lcdnw_pkg::VALUE_WIDTH-1:0];
            state_in = ST_REM;
         end
         ST_REM: begin
            job_in.digits[job_ff.count[lcdnw_pkg::IDX_W-1:0]] = rem_digit;
            job_in.count = job_ff.count + lcdnw_pkg::CNT_W'(1);
            value_in     = quot_ff;
            state_in     = (quot_ff == '0) ? ST_PUSH : ST_DIV;
         end
         ST_PUSH: begin
            if (!job_full) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      value_ff <= value_in;
      quot_ff  <= quot_in;
      job_ff   <= job_in;
   end

   // A job leaves with at least one digit and never more than fit.
   a_push_has_digits: assert property (@(posedge clock) disable iff (reset)
      job_push |-> (job_ff.count != '0) &&
                   (job_ff.count <= lcdnw_pkg::CNT_W'(lcdnw_pkg::DIGITS)))
      else $error("front pushed a job with a bad digit count");

   // After a digit step the quotient has become the working value.
   a_rem_moves_on: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REM) |=> (value_ff == $past(quot_ff)))
      else $error("front lost the quotient after a digit step");

endmodule

// File: rtl/lcdnw_queue.sv
// Short queue of converted jobs between the front end and the sequencer.
// Depends on lcdnw_pkg for the job type and depth.
module lcdnw_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   output logic              q_full,
   input  lcdnw_pkg::job_type wr_data,
   input  logic              rd_en,
   output logic              q_empty,
   output lcdnw_pkg::job_type rd_data
);

   localparam int PTR_W = (lcdnw_pkg::QUEUE_DEPTH > 1) ? $clog2(lcdnw_pkg::QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(lcdnw_pkg::QUEUE_DEPTH + 1);

   lcdnw_pkg::job_type entry_ff [lcdnw_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [FILL_W-1:0]  fill_ff;
   logic               do_wr, do_rd;

   assign q_full  = (fill_ff == FILL_W'(lcdnw_pkg::QUEUE_DEPTH));
   assign q_empty = (fill_ff == '0);
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   // Pointers wrap at the depth.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(lcdnw_pkg::QUEUE_DEPTH - 1)) ?
                         '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_rd) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(lcdnw_pkg::QUEUE_DEPTH - 1)) ?
                         '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_wr && !do_rd) begin
            fill_ff <= fill_ff + FILL_W'(1);
         end else if (do_rd && !do_wr) begin
            fill_ff <= fill_ff - FILL_W'(1);
         end
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(lcdnw_pkg::QUEUE_DEPTH))
      else $error("queue fill count beyond depth");

endmodule

// File: rtl/lcdnw_back.sv
// Back end: turns each converted job into address and digit bus bytes.
// Depends on lcdnw_pkg; takes jobs from lcdnw_queue.
module lcdnw_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_empty,
   output logic              job_pop,
   input  lcdnw_pkg::job_type job_data,
   output logic              empty,
   input  logic              pop,
   output lcdnw_pkg::rsp_type rsp_data
);

   logic                        busy_ff, busy_in;
   logic                        phase_ff, phase_in;
   logic [lcdnw_pkg::IDX_W-1:0] idx_ff, idx_in;
   lcdnw_pkg::job_type          job_ff, job_in;
   logic [lcdnw_pkg::CNT_W-1:0] last_idx;
   logic [lcdnw_pkg::CNT_W-1:0] pos;
   logic                        at_last;
   logic                        out_xfer;
   logic [7:0]                  addr_byte;
   logic [7:0]                  digit_byte;

   // Least significant digit sits furthest right.
   assign last_idx = job_ff.count - lcdnw_pkg::CNT_W'(1);
   assign at_last  = (lcdnw_pkg::CNT_W'(idx_ff) == last_idx);
   assign pos      = last_idx - lcdnw_pkg::CNT_W'(idx_ff);

   // Address sum wraps at eight bits like the controller's adder.
   assign addr_byte  = 8'(job_ff.column) + 8'(pos)
                       + (job_ff.row ? lcdnw_pkg::ROW_OFFSET : 8'h00)
                       + lcdnw_pkg::SET_ADDR_CMD;
   assign digit_byte = lcdnw_pkg::ASCII_ZERO + 8'(job_ff.digits[idx_ff]);

   assign empty             = !busy_ff;
   assign rsp_data.is_data  = phase_ff;
   assign rsp_data.bus_byte = phase_ff ? digit_byte : addr_byte;
   assign rsp_data.last     = phase_ff && at_last;

   assign out_xfer = pop && busy_ff;
   // Load the next job when idle or right as the current run ends.
   assign job_pop  = !job_empty && (!busy_ff || (out_xfer && phase_ff && at_last));

   // Byte sequencer: command then data for each digit.
   always_comb begin
      busy_in  = busy_ff;
      phase_in = phase_ff;
      idx_in   = idx_ff;
      job_in   = job_ff;
      if (job_pop) begin
         job_in   = job_data;
         busy_in  = 1'b1;
         phase_in = 1'b0;
         idx_in   = '0;
      end else if (out_xfer) begin
         if (!phase_ff) begin
            phase_in = 1'b1;
         end else if (at_last) begin
            busy_in = 1'b0;
         end else begin
            phase_in = 1'b0;
            idx_in   = idx_ff + lcdnw_pkg::IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
      end
      job_ff <= job_in;
   end

   // A run ends only on the transfer of its final data byte.
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> $past(out_xfer && phase_ff && at_last))
      else $error("sequencer went idle before the last byte");

   // The digit index stays inside the job's digit count.
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (lcdnw_pkg::CNT_W'(idx_ff) < job_ff.count))
      else $error("digit index beyond digit count");

endmodule

// File: rtl/lcd_decimal_number_writer.sv
// Top level of the LCD decimal number writer: front end, job queue, sequencer.
// Depends on lcdnw_pkg, lcdnw_front, lcdnw_queue and lcdnw_back.
//
// Each number pushed in comes out as a run of bus bytes for a character
// display: for every decimal digit, least significant first, a set-address
// command and then the digit's ASCII code; the final byte carries last. Zero
// gives one command and '0'. The front end takes the number, then for each
// digit does a reciprocal multiply by one tenth and then the remainder, and
// then passes the job on, staying full until it has. The sequencer offers
// one byte per cycle while it is popped and jobs are waiting, two per digit,
// and works on the previous number while the front end converts the next,
// with up to two converted numbers waiting between them.
module lcd_decimal_number_writer (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  lcdnw_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output lcdnw_pkg::rsp_type rsp_data
);

   logic               front_push, queue_full;
   logic               back_pop, queue_empty;
   lcdnw_pkg::job_type front_job, queue_job;

   lcdnw_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .job_push (front_push),
      .job_full (queue_full),
      .job_data (front_job)
   );

   lcdnw_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (front_push),
      .q_full  (queue_full),
      .wr_data (front_job),
      .rd_en   (back_pop),
      .q_empty (queue_empty),
      .rd_data (queue_job)
   );

   lcdnw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (queue_empty),
      .job_pop   (back_pop),
      .job_data  (queue_job),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

// File: tb/tb_lcd_decimal_number_writer.sv
// Self-checking testbench for the LCD decimal number writer.
// Depends on lcdnw_pkg and lcd_decimal_number_writer; predicts every bus byte.
module tb_lcd_decimal_number_writer;

   localparam int CLOCK_PERIOD   = 12;
   localparam int RESET_CYCLES   = 5;
   localparam int RADIX          = 10;
   localparam int MAX_DIGITS     = 10;
   localparam int RANDOM_ITEMS   = 143;
   localparam int HOLDOFF_CYCLES = 250;
   localparam int STALL_LIMIT    = 3000;
   localparam int TAIL_CYCLES    = 40;

   logic               clock;
   logic               reset;
   logic               push;
   logic               full;
   lcdnw_pkg::req_type req_data;
   logic               empty;
   logic               pop;
   lcdnw_pkg::rsp_type rsp_data;

   // Numbers waiting to be offered, and bus bytes waiting to come out.
   lcdnw_pkg::req_type number_q[$];
   lcdnw_pkg::rsp_type bus_byte_q[$];

   int unsigned numbers_queued   = 0;
   int unsigned numbers_offered  = 0;
   int unsigned numbers_accepted = 0;
   int unsigned idle_cycles      = 0;
   int unsigned mismatches       = 0;
   int unsigned send_idle_pct    = 0;
   int unsigned recv_idle_pct    = 0;
   int unsigned holdoffs_asked   = 0;
   int unsigned holdoffs_served  = 0;
   int unsigned holdoff_left     = 0;

   lcd_decimal_number_writer dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Expands one number into its set-address commands and digit bytes,
   // least significant digit first, placed so the top digit sits at the column.
   function automatic void predict_bus_bytes(input lcdnw_pkg::req_type item);
      int unsigned        remaining;
      int unsigned        digit_val[MAX_DIGITS];
      int unsigned        n_digits;
      int unsigned        pos;
      lcdnw_pkg::rsp_type b;
      remaining = 32'(item.value);
      n_digits  = 0;
      if (remaining == 0) begin
         digit_val[0] = 0;
         n_digits     = 1;
      end
      while (remaining != 0 && n_digits < MAX_DIGITS) begin
         digit_val[n_digits] = remaining % RADIX;
         remaining           = remaining / RADIX;
         n_digits++;
      end
      for (int i = 0; i < n_digits; i++) begin
         pos = n_digits - 1 - i;
         // The address sum wraps at eight bits, like the hardware adder.
         b.is_data  = 1'b0;
         b.bus_byte = lcdnw_pkg::SET_ADDR_CMD + 8'(item.column) + 8'(pos)
                      + (item.row ? lcdnw_pkg::ROW_OFFSET : 8'd0);
         b.last     = 1'b0;
         bus_byte_q.push_back(b);
         b.is_data  = 1'b1;
         b.bus_byte = lcdnw_pkg::ASCII_ZERO + 8'(digit_val[i]);
         b.last     = (i + 1 == n_digits);
         bus_byte_q.push_back(b);
      end
   endfunction

   task automatic queue_number(input int unsigned value, input int unsigned column,
                               input bit row);
      lcdnw_pkg::req_type item;
      item.value  = value[lcdnw_pkg::VALUE_WIDTH-1:0];
      item.column = column[lcdnw_pkg::COL_W-1:0];
      item.row    = row;
      number_q.push_back(item);
      numbers_queued++;
   endtask

   // Random numbers spread over every digit count, columns mostly on the display.
   task automatic queue_random_numbers(input int unsigned count);
      int unsigned value;
      int unsigned column;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(9))
            0: value = 0;
            1: value = $urandom_range(9);
            2: value = $urandom_range(99, 10);
            3: value = $urandom_range(999, 100);
            4: value = $urandom_range(9999, 1000);
            5: value = $urandom_range(65535, 10000);
            6: value = 65535 - $urandom_range(15);
            default: value = $urandom_range(65535);
         endcase
         if ($urandom_range(4) == 0) begin
            column = $urandom_range(63, 40);
         end else begin
            column = $urandom_range(39);
         end
         queue_number(value, column, 1'($urandom_range(1)));
      end
   endtask

   // Driver: offers the next number at the falling edge once the last one transferred.
   always @(negedge clock) begin
      if (reset) begin
         push     <= 1'b0;
         req_data <= '0;
      end else if (!push || numbers_offered == numbers_accepted) begin
         if (number_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data <= number_q.pop_front();
            push     <= 1'b1;
            numbers_offered++;
         end else begin
            push <= 1'b0;
         end
      end
   end

   // Receiver: random pop, with a long hold-off when one is asked for.
   always @(negedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (holdoffs_asked != holdoffs_served) begin
            holdoffs_served = holdoffs_asked;
            holdoff_left    = HOLDOFF_CYCLES;
         end
         if (holdoff_left != 0) begin
            holdoff_left--;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Monitor: predicts on each input transfer and checks each output transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) begin
            predict_bus_bytes(req_data);
            numbers_accepted++;
         end
         if (pop && !empty) begin
            if (bus_byte_q.size() == 0) begin
               $display("%0t: unexpected byte, expected none, %s is_data=%0b byte=%h last=%0b",
                        $time, "actual", rsp_data.is_data, rsp_data.bus_byte,
                        rsp_data.last);
               mismatches++;
            end else begin
               if (rsp_data !== bus_byte_q[0]) begin
                  $display("%0t: mismatch, expected is_data=%0b byte=%h last=%0b,",
                           $time, bus_byte_q[0].is_data, bus_byte_q[0].bus_byte,
                           bus_byte_q[0].last);
                  $display("%0t:           actual is_data=%0b byte=%h last=%0b",
                           $time, rsp_data.is_data, rsp_data.bus_byte, rsp_data.last);
                  mismatches++;
               end
               void'(bus_byte_q.pop_front());
            end
         end
         if ((push && !full) || (pop && !empty)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
   end

   // Watchdog: ends the run when no transfer has happened for too long.
   initial begin
      while (idle_cycles < STALL_LIMIT) @(negedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   // Sequence: reset, then three idling phases, then drain and report.
   initial begin
      reset = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         @(posedge clock);
         case (phase)
            0: begin
               send_idle_pct = 10;
               recv_idle_pct = 57;
            end
            1: begin
               send_idle_pct = 57;
               recv_idle_pct = 10;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         // Long receiver stalls fill the block while numbers keep coming.
         if (phase != 1) begin
            holdoffs_asked++;
         end
         if (phase == 0) begin
            // Zero at both ends of the display and on both rows.
            queue_number(0, 0, 1'b0);
            queue_number(0, 39, 1'b1);
            // One through five digits, at each change of digit count.
            queue_number(1, 0, 1'b0);
            queue_number(9, 10, 1'b1);
            queue_number(10, 5, 1'b0);
            queue_number(99, 20, 1'b1);
            queue_number(100, 30, 1'b0);
            queue_number(999, 35, 1'b1);
            queue_number(1000, 1, 1'b0);
            queue_number(9999, 36, 1'b1);
            queue_number(10000, 2, 1'b0);
            queue_number(65535, 0, 1'b0);
            queue_number(65535, 35, 1'b1);
            // Columns past the display, and an address sum that wraps.
            queue_number(65535, 63, 1'b1);
            queue_number(0, 63, 1'b1);
            queue_number(12345, 40, 1'b0);
            queue_number(54321, 62, 1'b1);
            // Alternating bit patterns in value and column.
            queue_number(16'hAAAA, 6'b101010, 1'b0);
            queue_number(16'h5555, 6'b010101, 1'b1);
            queue_number(16'h8000, 6'b100000, 1'b1);
            queue_number(16'h7FFF, 6'b011111, 1'b0);
         end
         queue_random_numbers(RANDOM_ITEMS);
         while (numbers_accepted < numbers_queued) @(negedge clock);
      end

      while (bus_byte_q.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatches == 0 && bus_byte_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
